// File: rtl/rthb_pkg.sv
`timescale 1ns / 1ps

package rthb_pkg;

    localparam int QUO_W = 8;                     // quotient bits, one per divide cell

    localparam logic [7:0] HUE_STEP       = 8'd43;
    localparam logic [7:0] HUE_BASE_RED   = 8'd0;
    localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
    localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
    localparam logic [7:0] FULL_SCALE     = 8'd255;

    // Word handed from cell to cell: two restoring dividers side by side
    // plus the sideband that the output stage needs.
    typedef struct packed {
        logic [7:0] sat_rem;
        logic [7:0] sat_num;
        logic [7:0] sat_quo;
        logic [7:0] hi;
        logic [7:0] hue_rem;
        logic [7:0] hue_num;
        logic [7:0] hue_quo;
        logic [7:0] spread;
        logic [7:0] base;
        logic       neg;
        logic       grey;
        logic       black;
    } cell_word_t;

endpackage

// File: rtl/rthb_prep.sv
`timescale 1ns / 1ps

module rthb_prep
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output logic                down_valid,
    input  logic                down_ready,
    output rthb_pkg::cell_word_t down_word
);

    logic                 valid_reg;
    rthb_pkg::cell_word_t word_reg;
    rthb_pkg::cell_word_t word_next;

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  spread;
    logic [7:0]  minu;
    logic [7:0]  subt;
    logic [7:0]  base;
    logic [8:0]  diff;
    logic [8:0]  diff_neg;
    logic [7:0]  adiff;
    logic [15:0] sat_num;
    logic [15:0] hue_num;

    always_comb
    begin
        // red wins ties, then green
        if (red >= green && red >= blue)
        begin
            hi   = red;
            base = rthb_pkg::HUE_BASE_RED;
            minu = green;
            subt = blue;
        end
        else if (green >= blue)
        begin
            hi   = green;
            base = rthb_pkg::HUE_BASE_GREEN;
            minu = blue;
            subt = red;
        end
        else
        begin
            hi   = blue;
            base = rthb_pkg::HUE_BASE_BLUE;
            minu = red;
            subt = green;
        end

        lo = red;
        if (green < lo)
        begin
            lo = green;
        end
        if (blue < lo)
        begin
            lo = blue;
        end

        spread   = hi - lo;
        diff     = {1'b0, minu} - {1'b0, subt};
        diff_neg = 9'd0 - diff;
        adiff    = diff[8] ? diff_neg[7:0] : diff[7:0];
        sat_num  = {spread, 8'd0} - {8'd0, spread};
        hue_num  = 16'(adiff) * 16'(rthb_pkg::HUE_STEP);

        word_next.sat_rem = sat_num[15:8];
        word_next.sat_num = sat_num[7:0];
        word_next.sat_quo = '0;
        word_next.hi      = hi;
        word_next.hue_rem = hue_num[15:8];
        word_next.hue_num = hue_num[7:0];
        word_next.hue_quo = '0;
        word_next.spread  = spread;
        word_next.base    = base;
        word_next.neg     = diff[8];
        word_next.grey    = (spread == 8'd0);
        word_next.black   = (hi == 8'd0);
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_word  = word_reg;

endmodule

// File: rtl/rthb_div_cell.sv
`timescale 1ns / 1ps

module rthb_div_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  rthb_pkg::cell_word_t up_word,
    output logic                 down_valid,
    input  logic                 down_ready,
    output rthb_pkg::cell_word_t down_word
);

    logic                 valid_reg;
    rthb_pkg::cell_word_t word_reg;
    rthb_pkg::cell_word_t word_next;

    logic [8:0] sat_try;
    logic [8:0] hue_try;
    logic       sat_bit;
    logic       hue_bit;

    // One restoring step for each divider: shift in the next numerator bit,
    // subtract the divisor when it fits.
    always_comb
    begin
        word_next = up_word;

        sat_try = {up_word.sat_rem, up_word.sat_num[7]};
        sat_bit = (sat_try >= {1'b0, up_word.hi});
        if (sat_bit)
        begin
            sat_try = sat_try - {1'b0, up_word.hi};
        end
        word_next.sat_rem = sat_try[7:0];
        word_next.sat_num = {up_word.sat_num[6:0], 1'b0};
        word_next.sat_quo = {up_word.sat_quo[6:0], sat_bit};

        hue_try = {up_word.hue_rem, up_word.hue_num[7]};
        hue_bit = (hue_try >= {1'b0, up_word.spread});
        if (hue_bit)
        begin
            hue_try = hue_try - {1'b0, up_word.spread};
        end
        word_next.hue_rem = hue_try[7:0];
        word_next.hue_num = {up_word.hue_num[6:0], 1'b0};
        word_next.hue_quo = {up_word.hue_quo[6:0], hue_bit};
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_word  = word_reg;

endmodule

// File: rtl/rthb_post.sv
`timescale 1ns / 1ps

module rthb_post
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  rthb_pkg::cell_word_t up_word,
    output logic                 hsv_valid,
    input  logic                 hsv_stall,
    output logic [7:0]           hue,
    output logic [7:0]           saturation,
    output logic [7:0]           brightness
);

    logic       valid_reg;
    logic [7:0] hue_reg;
    logic [7:0] sat_reg;
    logic [7:0] bri_reg;
    logic [7:0] hue_next;
    logic [7:0] sat_next;
    logic [7:0] bri_next;
    logic [7:0] hue_off;

    always_comb
    begin
        // quotient is a magnitude; negate it to truncate toward zero
        hue_off  = up_word.neg ? (8'd0 - up_word.hue_quo) : up_word.hue_quo;
        hue_next = up_word.base + hue_off;
        sat_next = up_word.sat_quo;
        bri_next = up_word.hi;
        if (up_word.black)
        begin
            hue_next = '0;
            sat_next = '0;
            bri_next = '0;
        end
        else if (up_word.grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    assign up_ready = !valid_reg || !hsv_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bri_reg <= bri_next;
        end
    end

    assign hsv_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bri_reg;

endmodule

// File: rtl/rgb_to_hsv_byte_unit.sv
`timescale 1ns / 1ps
// Path from an accepted pixel word to its HSV word: one setup
// stage, eight divide cells (one quotient bit each), one output register.
// Throughput: one word per cycle unless hsv_stall holds; each stage moves on
// whenever its successor frees, so bubbles close up while the output is stalled.
// Reset: rst_n clears all stage valid bits asynchronously; payload is not reset.

module rgb_to_hsv_byte_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       hsv_valid,
    input  logic       hsv_stall,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] brightness
);

    localparam int N = rthb_pkg::QUO_W;

    logic                 link_valid [N+1];
    logic                 link_ready [N+1];
    rthb_pkg::cell_word_t link_word  [N+1];
    logic                 pixel_ready;

    assign pixel_stall = !pixel_ready;

    rthb_prep u_prep
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (pixel_valid),
        .up_ready   (pixel_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .down_valid (link_valid[0]),
        .down_ready (link_ready[0]),
        .down_word  (link_word[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        rthb_div_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[i]),
            .up_ready   (link_ready[i]),
            .up_word    (link_word[i]),
            .down_valid (link_valid[i+1]),
            .down_ready (link_ready[i+1]),
            .down_word  (link_word[i+1])
        );
    end

    rthb_post u_post
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (link_valid[N]),
        .up_ready   (link_ready[N]),
        .up_word    (link_word[N]),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule

// File: rtl/rthb_checker.sv
`timescale 1ns / 1ps

module rthb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       pixel_valid,
    input logic       pixel_stall,
    input logic       hsv_valid,
    input logic       hsv_stall,
    input logic [7:0] hue,
    input logic [7:0] saturation,
    input logic [7:0] brightness
);

    localparam logic [3:0] DEPTH = 4'(rthb_pkg::QUO_W + 2);

    logic       in_fire;
    logic       out_fire;
    logic [3:0] count_reg;
    logic [3:0] count_next;

    assign in_fire  = pixel_valid && !pixel_stall;
    assign out_fire = hsv_valid && !hsv_stall;

    always_comb
    begin
        count_next = count_reg;
        if (in_fire && !out_fire)
        begin
            count_next = count_reg + 4'd1;
        end
        else if (out_fire && !in_fire)
        begin
            count_next = count_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // no word leaves that never entered
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> count_reg != 4'd0)
        else $error("output word without a matching input word");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH)
        else $error("more words in flight than pipeline stages");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && brightness == 8'd0 |-> hue == 8'd0 && saturation == 8'd0)
        else $error("black pixel with nonzero hue or saturation");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && saturation == 8'd0 |-> hue == 8'd0)
        else $error("grey pixel with nonzero hue");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv_stall |=> hsv_valid && $stable(hue) && $stable(saturation)
            && $stable(brightness))
        else $error("stalled output word changed");

endmodule

bind rgb_to_hsv_byte_unit rthb_checker u_rthb_checker (.*);
